[design/trm_pkg.sv]
package trm_pkg;

	localparam int TIME_W  = 32;
	localparam int CMD_W   = 2;
	localparam int EVT_W   = 3;
	localparam int TAP_W   = 8;
	localparam int STORE_W = 8;
	localparam int TMO_W   = 16;
	localparam int TOL_W   = 7;
	localparam int TEMPO_W = 16;
	localparam int CFG_W   = 16;
	localparam int TOLP_W  = STORE_W + TOL_W;

	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^TOLP_W
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int TOLQ_W      = TOLP_W + RECIP_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

	localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd100;
	localparam logic [TOL_W-1:0]   TOL_RESET     = 7'd25;
	localparam logic [TEMPO_W-1:0] TEMPO_ONE     = 16'd256;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX     = 16'hFFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_POLL   = 2'd0,
		CMD_TAP    = 2'd1,
		CMD_RECORD = 2'd2
	} cmd_t;

	typedef enum logic [EVT_W-1:0] {
		EV_NONE     = 3'd0,
		EV_SUCCESS  = 3'd1,
		EV_FAIL     = 3'd2,
		EV_RECORDED = 3'd3,
		EV_TIMEOUT  = 3'd4
	} event_t;

	typedef enum logic {
		REG_TIMEOUT   = 1'b0,
		REG_TOLERANCE = 1'b1
	} reg_idx_t;

endpackage

[design/trm_if.sv]
interface trm_tap_if;
	logic                        valid;
	logic                        ready;
	logic [trm_pkg::CMD_W-1:0]   command;
	logic [trm_pkg::TIME_W-1:0]  now_ticks;

	modport source(output valid, command, now_ticks, input ready);
	modport sink(input valid, command, now_ticks, output ready);
endinterface

interface trm_report_if #(parameter int LEN_W = 6);
	logic                       valid;
	logic                       ready;
	logic [trm_pkg::EVT_W-1:0]  event_code;
	logic [trm_pkg::TAP_W-1:0]  progress;
	logic [LEN_W-1:0]           pattern_length;
	logic                       is_recording;

	modport source(output valid, event_code, progress, pattern_length, is_recording,
		input ready);
	modport sink(input valid, event_code, progress, pattern_length, is_recording,
		output ready);
endinterface

[design/trm_store.sv]
module trm_store #(
	parameter int DEPTH = 32
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [trm_pkg::STORE_W-1:0]  wdata,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [trm_pkg::STORE_W-1:0]  rdata
);

	logic [trm_pkg::STORE_W-1:0] mem [DEPTH];
	logic [trm_pkg::STORE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/trm_div.sv]
module trm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [trm_pkg::TEMPO_W-1:0]  dividend,
	input  logic [trm_pkg::TIME_W-1:0]   divisor,
	output logic                         done,
	output logic [trm_pkg::TEMPO_W-1:0]  quotient
);

	localparam int QW = trm_pkg::TEMPO_W;
	localparam int CW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [QW-1:0] num_q;
	logic [QW-1:0] rem_q;
	logic [trm_pkg::TIME_W-1:0] dvs_q;

	logic [QW:0]   trial;
	logic          fits;

	always_comb begin
		trial = {rem_q, num_q[QW-1]};
		fits  = {{(trm_pkg::TIME_W-QW-1){1'b0}}, trial} >= dvs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit a cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= QW'(trial - dvs_q[QW:0]);
			end else begin
				rem_q <= trial[QW-1:0];
			end
			num_q <= {num_q[QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

[design/tap_rhythm_recorder_matcher.sv]
// Tap rhythm recorder and matcher.
// Items arrive on the tap channel (command, now_ticks) and each produces one
// result on the report channel (event_code, progress, pattern_length,
// is_recording), in order. Commands: poll, tap, start recording.
// Timeout and tolerance are set through the write port (cfg_we, cfg_index,
// cfg_wdata); the user must write them only while the block is idle, as the
// block itself does not enforce it. Intervals live in a single-port-write
// memory whose registered read is made ahead of use.
// Polls, record commands, record-mode taps and taps that only note the time
// go straight from execute to the result; a matching tap passes through
// multiply, scale and compare, and the tempo tap waits on the 16-step
// bit-serial divider. One item is in flight at a time; tap.ready rises as the
// result is loaded into the output register, so the next transfer overlaps a
// result still waiting on report.
// If report.ready stays low, a finished result holds in the block and no new
// item is taken until the output register frees.
// Reset clears mode, counters, stored length and last tap time, sets the
// tempo factor to one and loads default timeout and tolerance; the interval
// memory is not cleared.
module tap_rhythm_recorder_matcher #(
	parameter int PATTERN_DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	trm_tap_if.sink                    tap,
	trm_report_if.source               report,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [trm_pkg::CFG_W-1:0]  cfg_wdata
);

	localparam int AW  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int PW  = $clog2(PATTERN_DEPTH + 1);
	localparam int TW  = trm_pkg::TIME_W;
	localparam int SW  = trm_pkg::STORE_W;
	localparam int MW  = TW + trm_pkg::TEMPO_W;
	localparam int TQW = trm_pkg::TOLQ_W;
	localparam int TLW = trm_pkg::TOLP_W;
	localparam int TPW = trm_pkg::TOLP_W + trm_pkg::RECIP_W;
	localparam logic [PW-1:0] DEPTH_P = PW'(PATTERN_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_MUL,
		S_TOL,
		S_CMP,
		S_FIN
	} state_t;

	state_t state_q;

	logic [trm_pkg::TMO_W-1:0]   timeout_q;
	logic [trm_pkg::TOL_W-1:0]   tol_pct_q;

	logic [trm_pkg::CMD_W-1:0]   cmd_q;
	logic [TW-1:0]               now_q;
	logic [TW-1:0]               last_q;
	logic [trm_pkg::TAP_W-1:0]   tap_q;
	logic [PW-1:0]               pos_q;
	logic [PW-1:0]               len_q;
	logic                        rec_q;
	logic [trm_pkg::TEMPO_W-1:0] tempo_q;
	logic [trm_pkg::EVT_W-1:0]   ev_q;

	logic [SW-1:0]               val_q;
	logic [TW-1:0]               diff_q;
	logic [MW-1:0]               prod_q;
	logic [trm_pkg::TOLP_W-1:0]  tolp_q;
	logic [TW-1:0]               scaled_q;
	logic [TQW-1:0]              tolv_q;

	logic [SW-1:0]               rd_data;
	logic [SW-1:0]               val;
	logic [TW-1:0]               diff;
	logic [trm_pkg::TAP_W-1:0]   tap_inc;
	logic [PW-1:0]               pos_inc;
	logic                        tap_active;
	logic                        rec_end;
	logic                        timed_out;
	logic                        is_tap;
	logic                        mem_we;
	logic [SW-1:0]               mem_wdata;
	logic                        div_start;
	logic                        div_done;
	logic [trm_pkg::TEMPO_W-1:0] div_q;
	logic [TPW-1:0]              tol_full;
	logic [TW-1:0]               lower;
	logic [TW:0]                 upper;
	logic                        match;
	logic                        out_free;

	always_comb begin
		diff       = now_q - last_q;
		tap_inc    = (tap_q == '1) ? tap_q : tap_q + 1'b1;
		pos_inc    = pos_q + 1'b1;
		val        = (pos_q < DEPTH_P) ? rd_data : '0;
		tap_active = rec_q || (len_q >= PW'(2));
		rec_end    = (diff >= TW'(timeout_q)) || (pos_inc >= DEPTH_P);
		timed_out  = (tap_q != '0) && (diff > TW'(timeout_q));
		is_tap     = (state_q == S_EXEC) && (cmd_q == trm_pkg::CMD_TAP) && tap_active
			&& (tap_inc != 8'd1);
		mem_we     = is_tap && rec_q && (pos_q < DEPTH_P);
		mem_wdata  = (diff > TW'(255)) ? '1 : diff[SW-1:0];
		div_start  = is_tap && !rec_q && (tap_inc == 8'd2) && (diff != '0);
		tol_full   = TPW'(tolp_q) * TPW'(trm_pkg::RECIP_100);
		lower      = (scaled_q > TW'(tolv_q)) ? scaled_q - TW'(tolv_q) : '0;
		upper      = {1'b0, scaled_q} + (TW + 1)'(tolv_q);
		match      = (TW'(val_q) >= lower) && ((TW + 1)'(val_q) <= upper);
		out_free   = !report.valid || report.ready;
	end

	assign tap.ready = (state_q == S_IDLE);

	trm_store #(
		.DEPTH(PATTERN_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (pos_q[AW-1:0]),
		.wdata (mem_wdata),
		.raddr (pos_q[AW-1:0]),
		.rdata (rd_data)
	);

	trm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({val, 8'd0}),
		.divisor  (diff),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= trm_pkg::TIMEOUT_RESET;
			tol_pct_q <= trm_pkg::TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				trm_pkg::REG_TIMEOUT:   timeout_q <= cfg_wdata[trm_pkg::TMO_W-1:0];
				trm_pkg::REG_TOLERANCE: tol_pct_q <= cfg_wdata[trm_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tap.valid && tap.ready) begin
			cmd_q <= tap.command;
			now_q <= tap.now_ticks;
		end
		if (state_q == S_EXEC) begin
			val_q  <= val;
			diff_q <= diff;
		end
		prod_q   <= MW'(diff_q) * MW'(tempo_q);
		tolp_q   <= TLW'(val_q) * TLW'(tol_pct_q);
		scaled_q <= (prod_q[MW-1:TW+8] != '0) ? '1 : prod_q[TW+7:8];
		tolv_q   <= tol_full[TPW-1:trm_pkg::RECIP_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			last_q         <= '0;
			tap_q          <= '0;
			pos_q          <= '0;
			len_q          <= '0;
			rec_q          <= 1'b0;
			tempo_q        <= trm_pkg::TEMPO_ONE;
			ev_q           <= trm_pkg::EV_NONE;
			report.valid   <= 1'b0;
			report.event_code     <= trm_pkg::EV_NONE;
			report.progress       <= '0;
			report.pattern_length <= '0;
			report.is_recording   <= 1'b0;
		end else begin
			if (report.valid && report.ready && state_q != S_FIN) begin
				report.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (tap.valid) begin
						ev_q    <= trm_pkg::EV_NONE;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q)
						trm_pkg::CMD_POLL: begin
							state_q <= S_FIN;
							if (timed_out) begin
								if (rec_q) begin
									if (tap_q > 8'd1) begin
										len_q <= pos_q;
										rec_q <= 1'b0;
										tap_q <= '0;
										pos_q <= '0;
										ev_q  <= trm_pkg::EV_RECORDED;
									end
								end else begin
									ev_q  <= (tap_q == 8'd1) ? trm_pkg::EV_TIMEOUT
										: trm_pkg::EV_FAIL;
									tap_q <= '0;
									pos_q <= '0;
								end
							end
						end
						trm_pkg::CMD_TAP: begin
							if (!tap_active) begin
								state_q <= S_FIN;
							end else begin
								last_q <= now_q;
								if (tap_inc == 8'd1) begin
									tap_q   <= tap_inc;
									state_q <= S_FIN;
								end else if (rec_q) begin
									state_q <= S_FIN;
									if (rec_end) begin
										len_q <= pos_inc;
										rec_q <= 1'b0;
										tap_q <= '0;
										pos_q <= '0;
										ev_q  <= trm_pkg::EV_RECORDED;
									end else begin
										tap_q <= tap_inc;
										pos_q <= pos_inc;
									end
								end else if (tap_inc == 8'd2) begin
									tap_q <= tap_inc;
									pos_q <= pos_inc;
									if (diff == '0) begin
										tempo_q <= trm_pkg::TEMPO_MAX;
										state_q <= S_FIN;
									end else begin
										state_q <= S_DIV;
									end
								end else begin
									tap_q   <= tap_inc;
									pos_q   <= pos_inc;
									state_q <= S_MUL;
								end
							end
						end
						trm_pkg::CMD_RECORD: begin
							len_q   <= '0;
							rec_q   <= 1'b1;
							tap_q   <= '0;
							pos_q   <= '0;
							state_q <= S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						tempo_q <= div_q;
						state_q <= S_FIN;
					end
				end
				S_MUL: state_q <= S_TOL;
				S_TOL: state_q <= S_CMP;
				S_CMP: begin
					state_q <= S_FIN;
					if (match) begin
						if (pos_q == len_q) begin
							tap_q <= '0;
							pos_q <= '0;
							ev_q  <= trm_pkg::EV_SUCCESS;
						end
					end else begin
						tap_q <= '0;
						pos_q <= '0;
						ev_q  <= trm_pkg::EV_FAIL;
					end
				end
				S_FIN: begin
					if (out_free) begin
						report.valid          <= 1'b1;
						report.event_code     <= ev_q;
						report.progress       <= tap_q;
						report.pattern_length <= len_q;
						report.is_recording   <= rec_q;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[tb/tap_rhythm_recorder_matcher_tb.sv]
`timescale 1ns / 100ps

module tap_rhythm_recorder_matcher_tb;

	localparam int DEPTH = 32;
	localparam int LEN_W = 6;
	localparam int PERCENT = 100;
	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS = 490;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int SETTLE_CYCLES = 30;
	localparam int SHOWN_MISMATCHES = 10;
	localparam logic [trm_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		trm_pkg::event_t                code;
		logic [trm_pkg::TAP_W-1:0]      taps;
		logic [LEN_W-1:0]               len;
		logic                           rec;
	} report_t;

	class report_scoreboard;
		logic [trm_pkg::TMO_W-1:0]   timeout;
		logic [trm_pkg::TOL_W-1:0]   tol_pct;
		logic [trm_pkg::STORE_W-1:0] intervals [DEPTH];
		int unsigned                 stored_len;
		bit                          rec_mode;
		int unsigned                 taps;
		int unsigned                 pos;
		logic [trm_pkg::TIME_W-1:0]  last_tap;
		logic [trm_pkg::TEMPO_W-1:0] tempo;
		report_t                     expected_reports [$];
		int unsigned                 errors;

		function new();
			timeout = trm_pkg::TIMEOUT_RESET;
			tol_pct = trm_pkg::TOL_RESET;
			foreach (intervals[i])
				intervals[i] = '0;
			stored_len = 0;
			rec_mode = 1'b0;
			taps = 0;
			pos = 0;
			last_tap = '0;
			tempo = trm_pkg::TEMPO_ONE;
			errors = 0;
		endfunction

		function logic [trm_pkg::STORE_W-1:0] read_interval(int unsigned idx);
			return (idx < DEPTH) ? intervals[idx] : '0;
		endfunction

		function trm_pkg::event_t close_recording();
			stored_len = pos;
			rec_mode = 1'b0;
			taps = 0;
			pos = 0;
			return trm_pkg::EV_RECORDED;
		endfunction

		function trm_pkg::event_t tap_event(logic [trm_pkg::TIME_W-1:0] now);
			logic [trm_pkg::TIME_W-1:0]  diff;
			logic [trm_pkg::STORE_W-1:0] val;
			logic [63:0]                 d64, v64, t64, quot, scaled, tolv, lower, upper;
			if (!rec_mode && stored_len < 2)
				return trm_pkg::EV_NONE;
			diff = now - last_tap;
			last_tap = now;
			if (taps < 255)
				taps++;
			if (taps == 1)
				return trm_pkg::EV_NONE;
			if (rec_mode) begin
				if (pos < DEPTH)
					intervals[pos] = (diff > 255) ? {trm_pkg::STORE_W{1'b1}}
						: diff[trm_pkg::STORE_W-1:0];
				pos++;
				if (diff >= timeout || pos >= DEPTH)
					return close_recording();
				return trm_pkg::EV_NONE;
			end
			val = read_interval(pos);
			pos++;
			d64 = 64'(diff);
			v64 = 64'(val);
			if (taps == 2) begin
				if (diff == 0) begin
					tempo = trm_pkg::TEMPO_MAX;
				end else begin
					quot = (v64 << 8) / d64;
					tempo = (quot > trm_pkg::TEMPO_MAX) ? trm_pkg::TEMPO_MAX
						: quot[trm_pkg::TEMPO_W-1:0];
				end
				return trm_pkg::EV_NONE;
			end
			t64 = 64'(tempo);
			scaled = (d64 * t64) >> 8;
			if (scaled > 64'hFFFF_FFFF)
				scaled = 64'hFFFF_FFFF;
			t64 = 64'(tol_pct);
			tolv = (v64 * t64) / PERCENT;
			lower = (scaled > tolv) ? scaled - tolv : 64'd0;
			upper = scaled + tolv;
			if (v64 >= lower && v64 <= upper) begin
				if (pos == stored_len) begin
					taps = 0;
					pos = 0;
					return trm_pkg::EV_SUCCESS;
				end
				return trm_pkg::EV_NONE;
			end
			taps = 0;
			pos = 0;
			return trm_pkg::EV_FAIL;
		endfunction

		function trm_pkg::event_t poll_event(logic [trm_pkg::TIME_W-1:0] now);
			logic [trm_pkg::TIME_W-1:0] elapsed;
			trm_pkg::event_t            ev;
			elapsed = now - last_tap;
			if (taps > 0 && elapsed > timeout) begin
				if (rec_mode) begin
					if (taps > 1)
						return close_recording();
				end else begin
					ev = (taps == 1) ? trm_pkg::EV_TIMEOUT : trm_pkg::EV_FAIL;
					taps = 0;
					pos = 0;
					return ev;
				end
			end
			return trm_pkg::EV_NONE;
		endfunction

		function void note_item(logic [trm_pkg::CMD_W-1:0] cmd,
				logic [trm_pkg::TIME_W-1:0] now);
			report_t r;
			r.code = trm_pkg::EV_NONE;
			case (cmd)
				trm_pkg::CMD_POLL: r.code = poll_event(now);
				trm_pkg::CMD_TAP: r.code = tap_event(now);
				trm_pkg::CMD_RECORD: begin
					stored_len = 0;
					rec_mode = 1'b1;
					taps = 0;
					pos = 0;
				end
				default: ;
			endcase
			r.taps = taps[trm_pkg::TAP_W-1:0];
			r.len = stored_len[LEN_W-1:0];
			r.rec = rec_mode;
			expected_reports.push_back(r);
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (expected_reports.size() == 0) begin
				errors++;
				if (errors <= SHOWN_MISMATCHES)
					$display("%0t: unexpected report: event %0d progress %0d length %0d rec %0d",
						$realtime, got.code, got.taps, got.len, got.rec);
				return;
			end
			want = expected_reports.pop_front();
			if (got.code !== want.code || got.taps !== want.taps || got.len !== want.len
					|| got.rec !== want.rec) begin
				errors++;
				if (errors <= SHOWN_MISMATCHES) begin
					$write("%0t: mismatch: expected event %0d progress %0d length %0d rec %0d,",
						$realtime, want.code, want.taps, want.len, want.rec);
					$display(" got event %0d progress %0d length %0d rec %0d",
						got.code, got.taps, got.len, got.rec);
				end
			end
		endfunction

		function bit busy();
			return expected_reports.size() != 0;
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic                      cfg_index;
	logic [trm_pkg::CFG_W-1:0] cfg_wdata;

	trm_tap_if tap();
	trm_report_if #(.LEN_W(LEN_W)) report();

	tap_rhythm_recorder_matcher #(.PATTERN_DEPTH(DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.tap       (tap.sink),
		.report    (report.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	report_scoreboard           sb = new();
	bit                         steady = 1'b0;
	bit                         hold_req = 1'b0;
	logic [trm_pkg::TIME_W-1:0] tap_time;
	int unsigned                items_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && report.valid && report.ready)
			sb.check_report(report_t'{trm_pkg::event_t'(report.event_code), report.progress,
				report.pattern_length, report.is_recording});
	end

	initial begin
		report.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				report.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				report.ready <= steady || ($urandom_range(99) >= 31);
			end
		end
	end

	task automatic send_item(input logic [trm_pkg::CMD_W-1:0] cmd,
			input logic [trm_pkg::TIME_W-1:0] stamp);
		tap.valid <= 1'b1;
		tap.command <= cmd;
		tap.now_ticks <= stamp;
		@(posedge clk);
		while (!tap.ready)
			@(posedge clk);
		sb.note_item(cmd, stamp);
		items_sent++;
		if (!steady && $urandom_range(99) < 31) begin
			tap.valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	endtask

	task automatic tap_after(input logic [trm_pkg::TIME_W-1:0] gap);
		tap_time = tap_time + gap;
		send_item(trm_pkg::CMD_TAP, tap_time);
	endtask

	task automatic poll_after(input logic [trm_pkg::TIME_W-1:0] gap);
		send_item(trm_pkg::CMD_POLL, tap_time + gap);
	endtask

	// drop valid and wait until every transfer has its report
	task automatic go_quiet();
		tap.valid <= 1'b0;
		while (sb.busy())
			@(posedge clk);
	endtask

	task automatic set_regs(input logic [trm_pkg::TMO_W-1:0] to,
			input logic [trm_pkg::TOL_W-1:0] tl);
		cfg_we <= 1'b1;
		cfg_index <= trm_pkg::REG_TIMEOUT;
		cfg_wdata <= to;
		@(posedge clk);
		cfg_index <= trm_pkg::REG_TOLERANCE;
		cfg_wdata <= {{(trm_pkg::CFG_W - trm_pkg::TOL_W){1'b0}}, tl};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.timeout = to;
		sb.tol_pct = tl;
	endtask

	task automatic record_run();
		int unsigned n, kind, hi, i;
		n = ($urandom_range(5) == 0) ? $urandom_range(29, 34) : $urandom_range(1, 8);
		kind = $urandom_range(3);
		send_item(trm_pkg::CMD_RECORD, $urandom());
		tap_after(($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 500));
		for (i = 0; i < n && sb.rec_mode; i++) begin
			hi = (sb.timeout == 0) ? 0 : ((sb.timeout > 400) ? 400 : sb.timeout - 1);
			if ($urandom_range(9) == 0)
				poll_after($urandom_range(0, sb.timeout));
			tap_after($urandom_range(0, hi));
		end
		if (sb.rec_mode) begin
			case (kind)
				0, 3: tap_after(sb.timeout + $urandom_range(0, 40));
				1: poll_after(sb.timeout + 1 + $urandom_range(0, 40));
				default: ;
			endcase
		end
	endtask

	task automatic listen_run();
		int unsigned                 n, m, i, style;
		logic [trm_pkg::TIME_W-1:0]  gap;
		logic [trm_pkg::STORE_W-1:0] pat [DEPTH];
		n = sb.stored_len;
		style = $urandom_range(9);
		pat = sb.intervals;
		if (n < 2 || sb.rec_mode) begin
			repeat ($urandom_range(1, 3)) tap_after($urandom_range(0, 300));
			return;
		end
		m = $urandom_range(1, 4);
		tap_after(($urandom_range(1) == 0) ? $urandom() : $urandom_range(0, 2000));
		if (style == 4) begin
			poll_after(sb.timeout + 1 + $urandom_range(0, 20));
			return;
		end
		tap_after(m * pat[0]);
		for (i = 1; i < n && sb.taps != 0; i++) begin
			gap = m * pat[i];
			if (style < 2 && $urandom_range(3) == 0)
				gap = gap + $urandom_range(0, 6) - 3;
			else if (style == 2 && $urandom_range(5) == 0)
				gap = $urandom_range(0, 1000);
			if (style == 3 && i == n / 2) begin
				poll_after(sb.timeout + 1 + $urandom_range(0, 20));
				return;
			end
			if (style == 5 && $urandom_range(3) == 0)
				poll_after($urandom_range(0, sb.timeout));
			tap_after(gap);
		end
	endtask

	task automatic noise();
		logic [31:0] pick;
		repeat ($urandom_range(0, 3)) begin
			pick = $urandom_range(3);
			send_item(pick[trm_pkg::CMD_W-1:0], $urandom());
		end
	endtask

	initial begin
		int unsigned                phase;
		logic [31:0]                pick;
		logic [trm_pkg::TMO_W-1:0]  to;
		logic [trm_pkg::TOL_W-1:0]  tl;
		arst_n <= 1'b0;
		tap.valid <= 1'b0;
		tap.command <= trm_pkg::CMD_POLL;
		tap.now_ticks <= '0;
		cfg_we <= 1'b0;
		cfg_index <= trm_pkg::REG_TIMEOUT;
		cfg_wdata <= '0;
		tap_time = '0;
		items_sent = 0;
		phase = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing stored yet: tap ignored, unknown command, idle poll
		tap_after(5);
		send_item(CMD_UNKNOWN, '1);
		send_item(trm_pkg::CMD_POLL, '1);
		// record across the counter wrap, one interval saturating
		send_item(trm_pkg::CMD_RECORD, '0);
		tap_time = 32'hFFFF_FFF0;
		tap_after(0);
		poll_after(200);
		tap_after(20);
		tap_after(40);
		tap_after(300);
		// double tempo match, zero first interval, single-tap timeout
		tap_after(656);
		tap_after(10);
		tap_after(20);
		tap_after(128);
		tap_after(1000);
		tap_after(0);
		tap_after(1);
		tap_after(1000);
		poll_after(101);

		go_quiet();
		set_regs('0, 7'd127);
		send_item(trm_pkg::CMD_RECORD, '0);
		tap_after(7);
		tap_after(0);
		tap_after(50);

		go_quiet();
		set_regs('1, '0);
		send_item(trm_pkg::CMD_RECORD, '1);
		tap_after(0);
		tap_after(32'd65535);

		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			go_quiet();
			case ($urandom_range(7))
				0: to = '0;
				1: to = 16'd1;
				2: to = '1;
				default: begin
					pick = $urandom_range(2, 600);
					to = pick[trm_pkg::TMO_W-1:0];
				end
			endcase
			case ($urandom_range(5))
				0: tl = '0;
				1: tl = 7'd100;
				2: tl = '1;
				default: begin
					pick = $urandom_range(1, 60);
					tl = pick[trm_pkg::TOL_W-1:0];
				end
			endcase
			set_regs(to, tl);
			steady = (phase == 2 || phase == 3);
			repeat ($urandom_range(1, 2)) begin
				record_run();
				if (phase == 1)
					hold_req = 1'b1;
				repeat ($urandom_range(2, 5)) listen_run();
				noise();
			end
			phase++;
		end

		go_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && !sb.busy())
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
design/trm_pkg.sv
design/trm_if.sv
design/trm_store.sv
design/trm_div.sv
design/tap_rhythm_recorder_matcher.sv
tb/tap_rhythm_recorder_matcher_tb.sv
